[hdl/lfa_pkg.sv]
package lfa_pkg;

  // Bitmap row width: one memory word holds this many offset bits.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;
  localparam int unsigned ADDR_W = 32;

  // Configuration register indexes
  localparam logic CFG_FIRST = 1'b0;
  localparam logic CFG_LAST  = 1'b1;

  // Request kinds carried in tuser
  localparam logic ACT_OBTAIN  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RLS_WR,
    ST_DONE
  } state_e;

  // Result of examining one bitmap row
  typedef struct packed {
    logic             hit;       // a usable free bit exists in this row
    logic [BIT_W-1:0] idx;       // lowest such bit
    logic             last_row;  // no usable offsets past this row
  } pick_t;

endpackage

[hdl/lfa_ram.sv]
module lfa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/lfa_pick.sv]
module lfa_pick #(
  parameter int unsigned CNT_W = 9,
  parameter int unsigned ROW_W = 3
) (
  input  logic [lfa_pkg::WORD_W-1:0] word_i,
  input  logic [CNT_W-1:0]           limit_i,
  input  logic [ROW_W-1:0]           row_i,
  output lfa_pkg::pick_t             pick_o
);
  import lfa_pkg::*;

  localparam int unsigned EXT_W = (CNT_W > ROW_W + BIT_W) ? CNT_W + 1 : ROW_W + BIT_W + 1;

  logic [EXT_W-1:0]  base;
  logic [EXT_W-1:0]  rem;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] masked;

  // Usable bits left from the start of this row: limit minus row base.
  assign base = EXT_W'({row_i, BIT_W'(0)});
  assign rem  = EXT_W'(limit_i) - base;

  always_comb begin
    if (rem[EXT_W-1] || (rem == '0)) begin
      mask = '0;
    end else if (rem >= EXT_W'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_W{1'b1}} << rem[BIT_W-1:0]);
    end
  end

  assign masked = word_i & mask;

  // Priority encode: lowest set bit wins.
  always_comb begin
    pick_o.idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (masked[b]) begin
        pick_o.idx = BIT_W'(b);
      end
    end
    pick_o.hit      = |masked;
    pick_o.last_row = rem[EXT_W-1] || (rem <= EXT_W'(WORD_W));
  end

endmodule

[hdl/lowest_free_address_allocator_top.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/tready         tdata: address; tuser: action
// m_axis    out  m_axis_tvalid/tready         tdata: leased_address; tuser: pool_empty
// cfg       in   cfg_we_i (no wait)           cfg_index_i selects first/last, cfg_wdata_i
//
// The free bitmap lives in one RAM of 32-bit rows, ceil(POOL_SIZE/32) rows deep.
// Obtain: a decode state, scan states (one row read and priority-encoded per cycle), then
// a done state that loads the output register; with no usable offsets decode goes to done.
// Release: decode issues the row read, the next cycle writes it back; one outside the pool
// drops in decode. Every item returns to idle, the only state that takes a transfer.
// Reset and every config write run a clearing pass over every row, tready low.
// A result waits in the output register while the next item runs; an obtain holds in done
// only while the previous result is still stalled.
module lowest_free_address_allocator_top #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] address
  input  logic        s_axis_tuser_i,   // [0] action
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] leased_address
  output logic        m_axis_tuser_o    // [0] pool_empty
);
  import lfa_pkg::*;

  localparam int unsigned OFF_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned CNT_W = OFF_W + 1;
  localparam int unsigned ROWS  = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LOC_W = ROW_W + BIT_W;
  localparam int unsigned N_RST = (POOL_SIZE < 256) ? POOL_SIZE : 256;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] first_q, last_q;
  logic [CNT_W-1:0]  n_q;
  logic [ROW_W-1:0]  clr_q;
  logic [ROW_W-1:0]  scan_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_empty_q;

  logic              act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LOC_W-1:0]  rls_loc_q;
  logic [LOC_W-1:0]  found_q;
  logic              empty_q;

  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ROW_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  pick_t             pick;
  logic [ADDR_W:0]   rls_diff;
  logic              rls_ok;
  logic [LOC_W-1:0]  rls_loc;
  logic              out_free;

  lfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lfa_pick #(
    .CNT_W (CNT_W),
    .ROW_W (ROW_W)
  ) u_pick (
    .word_i  (ram_rdata),
    .limit_i (n_q),
    .row_i   (scan_q),
    .pick_o  (pick)
  );

  // Release range check: address within [first, last] and offset inside the pool.
  assign rls_diff = {1'b0, addr_q} - {1'b0, first_q};
  assign rls_ok   = !rls_diff[ADDR_W] && (addr_q <= last_q) &&
                    (rls_diff[ADDR_W-1:0] < ADDR_W'(POOL_SIZE));
  assign rls_loc  = rls_diff[LOC_W-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_empty_q;

  // Sequencer. Every RAM write lands before the next read of any row is issued,
  // so no forwarding path is needed.
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
        if (clr_q == ROW_W'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (act_q == ACT_RELEASE) begin
          ram_raddr = rls_loc[LOC_W-1:BIT_W];
          state_d   = rls_ok ? ST_RLS_WR : ST_IDLE;
        end else if (n_q == '0) begin
          state_d = ST_DONE;
        end else begin
          ram_raddr = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pick.hit) begin
          // take the bit
          ram_we    = 1'b1;
          ram_waddr = scan_q;
          ram_wdata = ram_rdata & ~(WORD_W'(1) << pick.idx);
          state_d   = ST_DONE;
        end else if (pick.last_row) begin
          state_d = ST_DONE;
        end else begin
          ram_raddr = scan_q + ROW_W'(1);
        end
      end
      ST_RLS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = rls_loc_q[LOC_W-1:BIT_W];
        ram_wdata = ram_rdata | (WORD_W'(1) << rls_loc_q[BIT_W-1:0]);
        state_d   = ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // a config write restarts the clearing pass
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      first_q     <= '0;
      last_q      <= ADDR_W'(255);
      n_q         <= CNT_W'(N_RST);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // usable offsets: min(last - first + 1, POOL_SIZE), zero when last < first
      if (last_q < first_q) begin
        n_q <= '0;
      end else if (({1'b0, last_q} - {1'b0, first_q}) < (ADDR_W + 1)'(POOL_SIZE)) begin
        n_q <= CNT_W'({1'b0, last_q} - {1'b0, first_q} + (ADDR_W + 1)'(1));
      end else begin
        n_q <= CNT_W'(POOL_SIZE);
      end

      if (cfg_we_i) begin
        clr_q <= '0;
        if (cfg_index_i == CFG_FIRST) begin
          first_q <= cfg_wdata_i;
        end else begin
          last_q <= cfg_wdata_i;
        end
      end else if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ROW_W'(1);
      end

      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      act_q  <= s_axis_tuser_i;
      addr_q <= s_axis_tdata_i;
    end
    if (state_q == ST_DECODE) begin
      rls_loc_q <= rls_loc;
      scan_q    <= '0;
      empty_q   <= (n_q == '0);
    end
    if (state_q == ST_SCAN) begin
      if (pick.hit) begin
        found_q <= {scan_q, pick.idx};
        empty_q <= 1'b0;
      end else if (pick.last_row) begin
        empty_q <= 1'b1;
      end else begin
        scan_q <= scan_q + ROW_W'(1);
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_addr_q  <= empty_q ? '0 : first_q + ADDR_W'(found_q);
      out_empty_q <= empty_q;
    end
  end

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && out_free |=> out_valid_q)
    else $error("result not loaded from done state");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> (out_addr_q == '0))
    else $error("empty pool result carries nonzero address");

  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(POOL_SIZE))
    else $error("usable offset count exceeds pool");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Bench for the lowest-free address allocator: requests stream in, grants stream
// out, and a software copy of the free bitmap predicts every grant.
module tb_top;

  localparam int unsigned POOL           = 256;
  localparam int unsigned SETTLE_CYCLES  = 16;    // release write-back plus clearing pass
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  // One request as it travels on the slave side.
  typedef struct packed {
    logic        action;
    logic [31:0] addr;
  } request_t;

  // One grant as it is expected on the master side.
  typedef struct packed {
    logic [31:0] addr;
    logic        empty;
  } grant_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = lfa_pkg::CFG_FIRST;
  logic [31:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;   // [31:0] address
  logic        s_axis_tuser_i  = lfa_pkg::ACT_OBTAIN;   // [0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;         // [31:0] leased_address
  logic        m_axis_tuser_o;         // [0] pool_empty

  lowest_free_address_allocator_top #(
    .POOL_SIZE (POOL)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the allocator: bounds and free bitmap, updated on every accepted request
  // and every bound write.
  logic [31:0]     bound_first = 32'd0;
  logic [31:0]     bound_last  = 32'd255;
  logic [POOL-1:0] free_bits   = '1;

  request_t request_q[$];   // requests not yet presented
  grant_t   grant_q[$];     // grants predicted but not yet seen

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int unsigned req_gap  = 0;
  int unsigned sink_gap = 0;

  int unsigned err_cnt     = 0;
  int unsigned n_requests  = 0;
  int unsigned n_obtains   = 0;
  int unsigned n_grants    = 0;
  int unsigned n_empty     = 0;
  int unsigned n_writes    = 0;
  int unsigned idle_cycles = 0;

  // Offsets that are inside [first, last] and inside the pool.
  function automatic logic [63:0] usable_offsets();
    logic [63:0] span;
    if (bound_last < bound_first) return 64'd0;
    span = {32'd0, bound_last} - {32'd0, bound_first} + 64'd1;
    return (span < POOL) ? span : 64'(POOL);
  endfunction

  // Update the shadow bitmap for one accepted request; queue the grant an obtain causes.
  function automatic void predict_lease(request_t rq);
    logic [63:0] n;
    logic [63:0] off;
    grant_t      g;
    bit          found;
    found   = 1'b0;
    g.addr  = 32'd0;
    g.empty = 1'b1;
    if (rq.action == lfa_pkg::ACT_OBTAIN) begin
      n = usable_offsets();
      for (int i = 0; i < POOL; i++) begin
        if (!found && i < n && free_bits[i]) begin
          found        = 1'b1;
          free_bits[i] = 1'b0;
          g.addr       = bound_first + 32'(i);
          g.empty      = 1'b0;
        end
      end
      grant_q.push_back(g);
    end else if (rq.addr >= bound_first && rq.addr <= bound_last) begin
      // Ignore releases that fall past the end of the pool.
      off = {32'd0, rq.addr} - {32'd0, bound_first};
      if (off < POOL) free_bits[off[$clog2(POOL)-1:0]] = 1'b1;
    end
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned pick_gap(bit en);
    int unsigned r;
    if (!en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver: present the next queued request once the current one is taken.
  always @(posedge clk_i) begin : drive_requests
    request_t rq;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        rq.action = s_axis_tuser_i;
        rq.addr   = s_axis_tdata_i;
        predict_lease(rq);
        n_requests++;
        if (rq.action == lfa_pkg::ACT_OBTAIN) n_obtains++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (req_gap > 0) begin
          req_gap         <= req_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          rq = request_q.pop_front();
          s_axis_tdata_i  <= rq.addr;
          s_axis_tuser_i  <= rq.action;
          s_axis_tvalid_i <= 1'b1;
          req_gap         <= pick_gap(src_idle_en);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Grant sink: stall at random, in stretches.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap        <= sink_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= pick_gap(sink_idle_en);
    end
  end

  // Grant monitor: compare every transfer against the oldest prediction.
  always @(posedge clk_i) begin : check_grants
    grant_t g;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_grants++;
      if (m_axis_tuser_o) n_empty++;
      if (grant_q.size() == 0) begin
        $error("grant with none pending: leased_address %h pool_empty %b",
               m_axis_tdata_o, m_axis_tuser_o);
        err_cnt++;
      end else begin
        g = grant_q.pop_front();
        if (m_axis_tdata_o !== g.addr) begin
          $error("leased_address: expected %h, got %h", g.addr, m_axis_tdata_o);
          err_cnt++;
        end
        if (m_axis_tuser_o !== g.empty) begin
          $error("pool_empty: expected %b, got %b", g.empty, m_axis_tuser_o);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer or bound write happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Hold until every request is taken and every grant has come; sample at the falling
  // edge so the clocked blocks have settled.
  task automatic wait_drained();
    @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid_i || grant_q.size() != 0)
      @(negedge clk_i);
  endtask

  // Write one bound while idle, then let the clearing pass finish.
  task automatic write_bound(input logic idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lfa_pkg::CFG_FIRST) bound_first = value;
    else bound_last = value;
    free_bits = '1;
    n_writes++;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_obtain();
    request_t rq;
    rq.action = lfa_pkg::ACT_OBTAIN;
    rq.addr   = $urandom;   // ignored on obtain; randomize to toggle the bits
    request_q.push_back(rq);
  endtask

  task automatic queue_release(input logic [31:0] addr);
    request_t rq;
    rq.action = lfa_pkg::ACT_RELEASE;
    rq.addr   = addr;
    request_q.push_back(rq);
  endtask

  // Release target: mostly inside the usable pool, the rest past the pool or range end,
  // below the range, at the extremes or anywhere.
  function automatic logic [31:0] pick_release_addr(logic [31:0] lo, logic [31:0] hi);
    logic [63:0] span;
    int unsigned r;
    span = (hi < lo) ? 64'd0 : {32'd0, hi} - {32'd0, lo} + 64'd1;
    r    = $urandom_range(0, 99);
    if (span != 0 && r < 70)
      return lo + $urandom_range(0, ((span < POOL) ? int'(span) : POOL) - 1);
    if (r < 80) return lo + $urandom_range(0, POOL + 40);
    if (r < 85) return lo - $urandom_range(1, 8);
    if (r < 90) return 32'd0;
    if (r < 93) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One random phase: set both bounds, then send a mix of obtains and releases. With
  // hold_mid, pause halfway until every grant has come.
  task automatic run_phase(input logic [31:0] lo, input logic [31:0] hi,
                           input int unsigned count, input int unsigned obtain_pct,
                           input bit src_idle, input bit sink_idle, input bit hold_mid);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_bound(lfa_pkg::CFG_FIRST, lo);
    write_bound(lfa_pkg::CFG_LAST, hi);
    @(negedge clk_i);
    src_idle_en  = src_idle;
    sink_idle_en = sink_idle;
    for (int k = 0; k < count; k++) begin
      if (hold_mid && k == count / 2) wait_drained();
      if ($urandom_range(0, 99) < obtain_pct) queue_obtain();
      else queue_release(pick_release_addr(lo, hi));
    end
  endtask

  initial begin : stimulus
    logic [31:0] lo;
    logic [31:0] hi;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset bounds [0, 255]: address zero is a real grant.
    queue_obtain();
    queue_obtain();
    queue_obtain();
    // Release twice, then take it back.
    queue_release(32'd1);
    queue_release(32'd1);
    queue_obtain();
    // Out of range releases and a release of a never-leased address.
    queue_release(32'hFFFF_FFFF);
    queue_release(32'd256);
    queue_release(32'd3);
    queue_obtain();
    queue_release(32'd0);
    queue_obtain();

    // Single address at the top of the space: grant, then empty, then grant again.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_bound(lfa_pkg::CFG_FIRST, 32'hFFFF_FFFF);
    write_bound(lfa_pkg::CFG_LAST, 32'hFFFF_FFFF);
    @(negedge clk_i);
    queue_obtain();
    queue_obtain();
    queue_release(32'hFFFF_FFFF);
    queue_obtain();

    // Empty range: last below first.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_bound(lfa_pkg::CFG_FIRST, 32'd10);
    write_bound(lfa_pkg::CFG_LAST, 32'd5);
    @(negedge clk_i);
    queue_obtain();
    queue_release(32'd7);
    queue_obtain();

    // Range longer than the pool: a release beyond the pool end is dropped.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_bound(lfa_pkg::CFG_FIRST, 32'h8000_0000);
    write_bound(lfa_pkg::CFG_LAST, 32'hFFFF_FFFF);
    @(negedge clk_i);
    queue_release(32'h8000_0000 + 32'd300);
    queue_obtain();
    queue_obtain();

    // Random phases over several bound settings.
    run_phase(32'd0, 32'd255, 80, 55, 1'b1, 1'b1, 1'b1);
    run_phase(32'h1234_5670, 32'h1234_5675, 80, 55, 1'b0, 1'b1, 1'b0);
    run_phase(32'd0, 32'd0, 40, 50, 1'b1, 1'b0, 1'b0);
    run_phase(32'hFFFF_FF00, 32'hFFFF_FFFF, 60, 65, 1'b0, 1'b0, 1'b0);
    // Drain the whole pool of a range that is longer than it.
    run_phase(32'd200, 32'hFFFF_FFFF, 280, 92, 1'b1, 1'b1, 1'b1);
    lo = $urandom;
    hi = lo + $urandom_range(0, 40);
    if (hi < lo) hi = 32'hFFFF_FFFF;
    run_phase(lo, hi, 60, 55, 1'b1, 1'b1, 1'b0);
    run_phase(32'hFFFF_FFF0, 32'h0000_0010, 20, 60, 1'b1, 1'b1, 1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (grant_q.size() != 0) begin
      $error("%0d grants never arrived", grant_q.size());
      err_cnt++;
    end

    $display("covered %0d requests (%0d obtains), %0d grants, %0d of them empty-pool",
             n_requests, n_obtains, n_grants, n_empty);
    $display("across %0d bound writes: empty, single, exact-pool and over-long ranges",
             n_writes);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
